FILE: src/assert_macros.svh
// assertion macros shared by the speed mixer rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OWSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OWSM_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OWSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define OWSM_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

FILE: src/owsm_pkg.sv
// shared types, constants and rounding functions of the omni wheel speed mixer
// no dependencies
package owsm_pkg;

  localparam int MAX_WHEELS = 4;
  localparam int TRIG_BITS  = 16;
  localparam int TRIG_FRAC  = TRIG_BITS - 1;
  localparam int KW         = $clog2(MAX_WHEELS);

  localparam int TW  = TRIG_BITS + 1;
  localparam int PW  = 2 * TW;
  localparam int AW  = TW + 16;
  localparam int MW  = AW + 1;
  localparam int SW  = MW + 17;
  localparam int SSH = TRIG_FRAC + 7;
  localparam int OW  = SW - SSH + 1;
  localparam int SPW = OW + 1;
  localparam int TRW = 14;

  localparam int RSH = 31 - TRIG_BITS;

  localparam logic [30:0] SC1 = 31'd1686629713;
  localparam logic [30:0] SC3 = 31'd693598668;
  localparam logic [30:0] SC5 = 31'd85569306;
  localparam logic [30:0] SC7 = 31'd5026995;
  localparam logic [30:0] SC9 = 31'd172272;
  localparam logic [3:0][30:0] HORNER_C = {SC1, SC3, SC5, SC7};

  localparam logic [2:0] REG_ANGLE_A  = 3'd0;
  localparam logic [2:0] REG_ANGLE_B  = 3'd1;
  localparam logic [2:0] REG_ANGLE_C  = 3'd2;
  localparam logic [2:0] REG_ANGLE_D  = 3'd3;
  localparam logic [2:0] REG_SCALE    = 3'd4;
  localparam logic [2:0] REG_INVERT   = 3'd5;
  localparam logic [2:0] REG_WHEELS   = 3'd6;

  typedef struct packed {
    logic [KW-1:0]         k;
    logic                  last;
    logic                  en;
    logic                  inv;
    logic signed [15:0]    vx;
    logic signed [15:0]    vy;
    logic signed [TRW-1:0] turn;
  } side_t;

  typedef struct packed {
    logic [15:0] sin_ang;
    logic [15:0] cos_ang;
    logic [15:0] ch_ang;
    side_t       side;
  } job_t;

  function automatic logic signed [TW-1:0] rnd_trig(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    r   = (mag + (PW'(1) << (TRIG_FRAC - 1))) >> TRIG_FRAC;
    return v[PW-1] ? -$signed(r[TW-1:0]) : $signed(r[TW-1:0]);
  endfunction

  function automatic logic signed [OW-1:0] rnd_spd(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW-1:0] r;
    mag = v[SW-1] ? SW'(-v) : SW'(v);
    r   = (mag + (SW'(1) << (SSH - 1))) >> SSH;
    return v[SW-1] ? -$signed(r[OW-1:0]) : $signed(r[OW-1:0]);
  endfunction

endpackage

FILE: src/owsm_cell.sv
// one horner step cell of the quarter-wave sine polynomial
// depends on owsm_pkg
module owsm_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] coef,
  input  logic [30:0] z2_i,
  input  logic [14:0] r_i,
  input  logic        neg_i,
  input  logic [30:0] p_i,
  output logic [30:0] z2_o,
  output logic [14:0] r_o,
  output logic        neg_o,
  output logic [30:0] p_o
);
  import owsm_pkg::*;

  logic [61:0] prod;
  logic [31:0] diff;

  assign prod = z2_i * p_i;
  assign diff = {1'b0, coef} - prod[61:30];

  always_ff @(posedge clk) begin
    if (en) begin
      z2_o  <= z2_i;
      r_o   <= r_i;
      neg_o <= neg_i;
      p_o   <= diff[30:0];
    end
  end
endmodule

FILE: src/owsm_trig.sv
// sine of a binary angle: fold, square, chain of horner cells, final scale
// depends on owsm_pkg and owsm_cell
module owsm_trig (
  input  logic                          clk,
  input  logic [5:0]                    adv,
  input  logic [15:0]                   ang,
  output logic signed [owsm_pkg::TW-1:0] val
);
  import owsm_pkg::*;

  logic [30:0] z2_w  [0:4];
  logic [14:0] r_w   [0:4];
  logic        neg_w [0:4];
  logic [30:0] p_w   [0:4];
  logic [14:0] r0;
  logic [45:0] fprod;
  logic [31:0] s;
  logic [31:0] t;

  assign r0 = ang[14] ? (15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      z2_w[0]  <= {29'(r0) * 29'(r0), 2'b00};
      r_w[0]   <= r0;
      neg_w[0] <= ang[15];
      p_w[0]   <= SC9;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_cell
    owsm_cell u_cell (
      .clk   (clk),
      .en    (adv[i+1]),
      .coef  (HORNER_C[i]),
      .z2_i  (z2_w[i]),
      .r_i   (r_w[i]),
      .neg_i (neg_w[i]),
      .p_i   (p_w[i]),
      .z2_o  (z2_w[i+1]),
      .r_o   (r_w[i+1]),
      .neg_o (neg_w[i+1]),
      .p_o   (p_w[i+1])
    );
  end

  assign fprod = r_w[4] * p_w[4];
  assign s     = (fprod[45:14] > 32'h4000_0000) ? 32'h4000_0000 : fprod[45:14];
  assign t     = (s + (32'd1 << (RSH - 1))) >> RSH;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      val <= neg_w[4] ? -$signed(t[TW-1:0]) : $signed(t[TW-1:0]);
    end
  end
endmodule

FILE: src/owsm_issue.sv
// command holding register and wheel sequencer, one wheel job per cycle while adv is high
// depends on owsm_pkg
module owsm_issue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [71:0]            in_tdata,
  input  logic [3:0][15:0]       angles,
  input  logic [3:0]             invert_mask,
  input  logic [2:0]             wheel_count,
  input  logic                   adv,
  output logic                   job_valid,
  output owsm_pkg::job_t         job
);
  import owsm_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic signed [15:0]    vx_r, vy_r;
  logic [15:0]           h_r;
  logic                  en_r;
  logic signed [TRW-1:0] turn_r;
  logic [KW-1:0]         last_k;
  logic                  is_last;
  logic                  accept;
  logic [16:0]           tmag;
  logic [16:0]           tx;
  logic [32:0]           tprod;
  logic [15:0]           vt;
  logic [15:0]           wa;

  assign last_k  = (wheel_count <= 3'd3) ? KW'(2) :
                   (wheel_count >= 3'(MAX_WHEELS)) ? KW'(MAX_WHEELS - 1) :
                   KW'(wheel_count - 3'd1);
  assign is_last = (k_r == last_k);
  assign in_tready = !busy_r || (adv && is_last);
  assign accept  = in_tvalid && in_tready;

  assign vt    = in_tdata[47:32];
  assign tmag  = vt[15] ? (17'd0 - {1'b0, vt}) : {1'b0, vt};
  assign tx    = {tmag[15:0], 1'b0} + 17'd5;
  assign tprod = tx * 16'd52429;

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (busy_r && adv) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        k_nxt = k_r + KW'(1);
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vx_r   <= in_tdata[15:0];
      vy_r   <= in_tdata[31:16];
      h_r    <= in_tdata[63:48];
      en_r   <= in_tdata[64];
      turn_r <= vt[15] ? -$signed({1'b0, tprod[31:19]}) : $signed({1'b0, tprod[31:19]});
    end
  end

  assign wa        = h_r + angles[k_r];
  assign job_valid = busy_r;

  always_comb begin
    job.sin_ang   = wa;
    job.cos_ang   = wa + 16'd16384;
    job.ch_ang    = h_r + 16'd16384;
    job.side.k    = k_r;
    job.side.last = is_last;
    job.side.en   = en_r;
    job.side.inv  = invert_mask[k_r];
    job.side.vx   = vx_r;
    job.side.vy   = vy_r;
    job.side.turn = turn_r;
  end
endmodule

FILE: src/omni_wheel_speed_mixer.sv
// top level of the omni wheel speed mixer: config registers, trig lanes, mixing stages
// depends on owsm_pkg, owsm_issue, owsm_trig and assert_macros.svh
//
//  port group | dir | payload
//  in_*       | in  | velocity command word, see in_tdata
//  out_*      | out | one wheel result word per wheel, tlast on the final wheel
//  cfg_*      | in  | register write, index and data
//
// a command issues one wheel job per cycle while stage 1 advances: 3 or 4 jobs, set by
// the single wheel sequencer; the next command is taken as its last wheel issues
// from accept to the first wheel word a job passes 6 trig stages and 6 mix stages
// every stage carries its own valid, so bubbles collapse and input keeps flowing while a
// result waits on out_tready till stages fill; synchronous active-low reset clears valids
`include "assert_macros.svh"
module omni_wheel_speed_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // vel_x, vel_y, vel_turn, heading, enable
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // wheel_index, bridge_in1, bridge_in2, duty
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import owsm_pkg::*;

  localparam int NST = 12;

  logic [3:0][15:0] angle_r;
  logic [15:0]      scale_r;
  logic [3:0]       invert_r;
  logic [2:0]       wheels_r;

  logic [NST:1]     v_r;
  logic [NST:1]     adv;
  logic             job_valid;
  job_t             job;
  side_t            side_r [1:NST-1];

  logic signed [TW-1:0] sin_v, cos_v, ch_v;
  logic signed [PW-1:0] sp_r, cp_r;
  logic signed [TW-1:0] p_r, q_r;
  logic signed [AW-1:0] a_r, b_r;
  logic signed [MW-1:0] m_r;
  logic signed [SW-1:0] mp_r;

  logic signed [OW-1:0]  s1;
  logic signed [SPW-1:0] spd;
  logic                  neg;
  logic [SPW-1:0]        mag;
  logic [15:0]           duty;

  logic [23:0] out_tdata_r;
  logic        out_tlast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r  <= {16'd0, 16'd43691, 16'd21845, 16'd0};
      scale_r  <= 16'd256;
      invert_r <= 4'd0;
      wheels_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ANGLE_A: angle_r[0] <= cfg_wdata;
        REG_ANGLE_B: angle_r[1] <= cfg_wdata;
        REG_ANGLE_C: angle_r[2] <= cfg_wdata;
        REG_ANGLE_D: angle_r[3] <= cfg_wdata;
        REG_SCALE:   scale_r    <= cfg_wdata;
        REG_INVERT:  invert_r   <= cfg_wdata[3:0];
        REG_WHEELS:  wheels_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    adv[NST] = !v_r[NST] || out_tready;
    for (int i = NST - 1; i >= 1; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 1; i <= NST; i++) begin
        if (adv[i]) begin
          v_r[i] <= (i == 1) ? job_valid : v_r[i-1];
        end
      end
    end
  end

  owsm_issue u_issue (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .angles      (angle_r),
    .invert_mask (invert_r),
    .wheel_count (wheels_r),
    .adv         (adv[1]),
    .job_valid   (job_valid),
    .job         (job)
  );

  owsm_trig u_sin (.clk(clk), .adv(adv[6:1]), .ang(job.sin_ang), .val(sin_v));
  owsm_trig u_cos (.clk(clk), .adv(adv[6:1]), .ang(job.cos_ang), .val(cos_v));
  owsm_trig u_ch  (.clk(clk), .adv(adv[6:1]), .ang(job.ch_ang),  .val(ch_v));

  always_ff @(posedge clk) begin
    if (adv[1]) side_r[1] <= job.side;
    for (int i = 2; i < NST; i++) begin
      if (adv[i]) side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      sp_r <= sin_v * ch_v;
      cp_r <= cos_v * ch_v;
    end
    if (adv[8]) begin
      p_r <= rnd_trig(sp_r);
      q_r <= rnd_trig(cp_r);
    end
    if (adv[9]) begin
      a_r <= p_r * side_r[8].vx;
      b_r <= q_r * side_r[8].vy;
    end
    if (adv[10]) begin
      m_r <= MW'(b_r) - MW'(a_r);
    end
    if (adv[11]) begin
      mp_r <= m_r * $signed({1'b0, scale_r});
    end
  end

  always_comb begin
    s1   = rnd_spd(mp_r);
    spd  = SPW'(s1) + SPW'(side_r[NST-1].turn);
    if (side_r[NST-1].inv) begin
      spd = -spd;
    end
    neg  = spd[SPW-1];
    mag  = neg ? SPW'(-spd) : SPW'(spd);
    duty = (mag > SPW'(16'hFFFF)) ? 16'hFFFF : mag[15:0];
    if (!side_r[NST-1].en) begin
      duty = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NST]) begin
      out_tdata_r <= {4'd0, duty, !neg, neg, 2'(side_r[NST-1].k)};
      out_tlast_r <= side_r[NST-1].last;
    end
  end

  assign out_tvalid = v_r[NST];
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `OWSM_ASSERT(a_dir_bits, clk, rst_n, out_tvalid |-> (out_tdata[2] ^ out_tdata[3]), "bridge bits not complementary")
  `OWSM_ASSERT(a_wheel3_last, clk, rst_n, (out_tvalid && out_tdata[1:0] == 2'd3) |-> out_tlast, "wheel 3 word without tlast")
  `OWSM_ASSERT(a_last_wheel, clk, rst_n, (out_tvalid && out_tlast) |-> out_tdata[1], "tlast on wheel 0 or 1")
  `OWSM_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_tvalid, "output valid after reset")
endmodule
